// ===== src/vgm_opl_command_converter_unit_macros.svh =====
// ----------------------------------------------------------------------------
// VGM OPL command converter assertion macros
// Property shorthands for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef VGM_OPL_COMMAND_CONVERTER_UNIT_MACROS_SVH
`define VGM_OPL_COMMAND_CONVERTER_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define VOCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define VOCC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VOCC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define VOCC_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif

`endif

// ===== src/vocc_pkg.sv =====
// ----------------------------------------------------------------------------
// vocc_pkg
// Opcodes, divider constants and shared types of the VGM command converter.
// ----------------------------------------------------------------------------
`default_nettype none

package vocc_pkg;

  // stream opcodes
  localparam logic [7:0] OPC_WRITE_A      = 8'h5A;
  localparam logic [7:0] OPC_WRITE_B      = 8'h5B;
  localparam logic [7:0] OPC_WRITE_C      = 8'h5C;
  localparam logic [7:0] OPC_WAIT_N       = 8'h61;
  localparam logic [7:0] OPC_WAIT_FRAME   = 8'h62;
  localparam logic [7:0] OPC_WAIT_2FRAMES = 8'h63;
  localparam logic [7:0] OPC_END          = 8'h66;

  // fixed frame increments
  localparam logic [7:0] INC_FRAME   = 8'd1;
  localparam logic [7:0] INC_2FRAMES = 8'd2;

  // samples / 735 as a reciprocal multiply, exact for any 16-bit count
  localparam int             SAMPLE_W  = 16;
  localparam int             DIV_MUL_W = 17;
  localparam logic [16:0]    DIV_MUL   = 17'd91305;
  localparam int             DIV_SHIFT = 26;
  localparam int             PROD_W    = SAMPLE_W + DIV_MUL_W;
  localparam int             QUOT_W    = PROD_W - DIV_SHIFT;

  // command queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int DELAY_W = 16;

  // parser phase, one-hot
  typedef enum logic [2:0] {
    PH_OPCODE = 3'b001,
    PH_FIRST  = 3'b010,
    PH_SECOND = 3'b100
  } phase_t;

  // classified command kinds
  typedef enum logic [2:0] {
    CMD_WRITE = 3'b001,
    CMD_DELAY = 3'b010,
    CMD_END   = 3'b100
  } cmd_kind_t;

  // one queued command: write uses both args, delay uses arg1 as increment
  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] arg0;
    logic [7:0] arg1;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [7:0]         reg_addr;
    logic [7:0]         reg_value;
    logic [DELAY_W-1:0] delay_ticks;
    logic               write_valid;
    logic               last;
  } rec_t;

endpackage

`default_nettype wire

// ===== src/vocc_in_if.sv =====
// ----------------------------------------------------------------------------
// vocc_in_if
// Byte stream channel: valid/ready with one stream byte per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface vocc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink   (input valid, input stream_byte, output ready);
endinterface

`default_nettype wire

// ===== src/vocc_out_if.sv =====
// ----------------------------------------------------------------------------
// vocc_out_if
// Register write record channel: valid/ready with one record per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface vocc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  reg_addr;
  logic [7:0]  reg_value;
  logic [15:0] delay_ticks;
  logic        write_valid;
  logic        last;

  modport source (output valid, output reg_addr, output reg_value, output delay_ticks,
                  output write_valid, output last, input ready);
  modport sink   (input valid, input reg_addr, input reg_value, input delay_ticks,
                  input write_valid, input last, output ready);
endinterface

`default_nettype wire

// ===== src/vocc_front.sv =====
// ----------------------------------------------------------------------------
// vocc_front
// Byte parser: tracks opcode/operand phase and emits classified commands.
// ----------------------------------------------------------------------------
`default_nettype none

module vocc_front (
  input  wire                   clk,
  input  wire                   rst_n,
  vocc_in_if.sink               in_stream,
  input  vocc_pkg::q_status_t   q_stat,
  output logic                  push,
  output vocc_pkg::cmd_t        push_cmd
);
  import vocc_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        wait_kind_r, wait_kind_nxt;
  logic [7:0]  first_r, first_nxt;
  logic        take;
  logic [7:0]  b;
  logic [SAMPLE_W-1:0] samples;
  logic [PROD_W-1:0]   prod;
  logic [QUOT_W-1:0]   quot;

  assign in_stream.ready = !q_stat.full;
  assign take            = in_stream.valid && in_stream.ready;
  assign b               = in_stream.stream_byte;

  // sample count / 735, registered by the queue entry
  assign samples = {b, first_r};
  assign prod    = PROD_W'(samples) * PROD_W'(DIV_MUL);
  assign quot    = prod[PROD_W-1:DIV_SHIFT];

  // phase and command decode
  always_comb begin
    phase_nxt     = phase_r;
    wait_kind_nxt = wait_kind_r;
    first_nxt     = first_r;
    push          = 1'b0;
    push_cmd.kind = CMD_WRITE;
    push_cmd.arg0 = first_r;
    push_cmd.arg1 = b;
    if (take) begin
      unique case (phase_r)
        PH_FIRST: begin
          first_nxt = b;
          phase_nxt = PH_SECOND;
        end
        PH_SECOND: begin
          phase_nxt = PH_OPCODE;
          push      = 1'b1;
          if (wait_kind_r) begin
            push_cmd.kind = CMD_DELAY;
            push_cmd.arg1 = 8'(quot);
          end
        end
        default: begin
          // opcode position
          phase_nxt = PH_OPCODE;
          unique case (b)
            OPC_WRITE_A, OPC_WRITE_B, OPC_WRITE_C: begin
              wait_kind_nxt = 1'b0;
              phase_nxt     = PH_FIRST;
            end
            OPC_WAIT_N: begin
              wait_kind_nxt = 1'b1;
              phase_nxt     = PH_FIRST;
            end
            OPC_WAIT_FRAME: begin
              push          = 1'b1;
              push_cmd.kind = CMD_DELAY;
              push_cmd.arg1 = INC_FRAME;
            end
            OPC_WAIT_2FRAMES: begin
              push          = 1'b1;
              push_cmd.kind = CMD_DELAY;
              push_cmd.arg1 = INC_2FRAMES;
            end
            OPC_END: begin
              push          = 1'b1;
              push_cmd.kind = CMD_END;
            end
            default: ;  // one-byte command, skipped
          endcase
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_OPCODE;
      wait_kind_r <= 1'b0;
      first_r     <= 8'd0;
    end else begin
      phase_r     <= phase_nxt;
      wait_kind_r <= wait_kind_nxt;
      first_r     <= first_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== src/vocc_queue.sv =====
// ----------------------------------------------------------------------------
// vocc_queue
// Small command FIFO between the parser and the record builder.
// ----------------------------------------------------------------------------
`default_nettype none

module vocc_queue (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   push,
  input  vocc_pkg::cmd_t        push_cmd,
  input  wire                   pop,
  output vocc_pkg::cmd_t        head,
  output vocc_pkg::q_status_t   q_stat
);
  import vocc_pkg::*;

  cmd_t              entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign q_stat.full  = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign head         = entries_r[rd_ptr_r];
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;

  // pointer and fill update
  always_comb begin
    wr_ptr_nxt = do_push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = QCNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// ===== src/vocc_back.sv =====
// ----------------------------------------------------------------------------
// vocc_back
// Record builder: holds the pending write, accumulates delay, drives records.
// ----------------------------------------------------------------------------
`default_nettype none

module vocc_back (
  input  wire                   clk,
  input  wire                   rst_n,
  input  vocc_pkg::cmd_t        head,
  input  vocc_pkg::q_status_t   q_stat,
  output logic                  pop,
  vocc_out_if.source            out_rec
);
  import vocc_pkg::*;

  logic [DELAY_W-1:0] accum_r, accum_nxt;
  logic               pend_valid_r, pend_valid_nxt;
  logic [7:0]         pend_reg_r, pend_reg_nxt;
  logic [7:0]         pend_val_r, pend_val_nxt;
  logic               out_valid_r, out_valid_nxt;
  rec_t               rec_r, rec_nxt;
  logic               emit, out_free;

  // a command may leave the queue once any record it makes has room
  assign emit     = (head.kind == CMD_END) || ((head.kind == CMD_WRITE) && pend_valid_r);
  assign out_free = !out_valid_r || out_rec.ready;
  assign pop      = !q_stat.empty && (!emit || out_free);

  always_comb begin
    accum_nxt      = accum_r;
    pend_valid_nxt = pend_valid_r;
    pend_reg_nxt   = pend_reg_r;
    pend_val_nxt   = pend_val_r;
    out_valid_nxt  = out_valid_r;
    rec_nxt        = rec_r;
    if (out_valid_r && out_rec.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (pop) begin
      unique case (head.kind)
        CMD_WRITE: begin
          if (pend_valid_r) begin
            rec_nxt       = '{pend_reg_r, pend_val_r, accum_r, 1'b1, 1'b0};
            out_valid_nxt = 1'b1;
          end
          pend_valid_nxt = 1'b1;
          pend_reg_nxt   = head.arg0;
          pend_val_nxt   = head.arg1;
          accum_nxt      = '0;
        end
        CMD_DELAY: begin
          accum_nxt = DELAY_W'(accum_r + DELAY_W'(head.arg1));
        end
        CMD_END: begin
          if (pend_valid_r) begin
            rec_nxt = '{pend_reg_r, pend_val_r, accum_r, 1'b1, 1'b1};
          end else begin
            rec_nxt = '{8'd0, 8'd0, {DELAY_W{1'b0}}, 1'b0, 1'b1};
          end
          out_valid_nxt  = 1'b1;
          pend_valid_nxt = 1'b0;
          pend_reg_nxt   = 8'd0;
          pend_val_nxt   = 8'd0;
          accum_nxt      = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r      <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      accum_r      <= accum_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pend_reg_r <= pend_reg_nxt;
    pend_val_r <= pend_val_nxt;
    rec_r      <= rec_nxt;
  end

  assign out_rec.valid       = out_valid_r;
  assign out_rec.reg_addr    = rec_r.reg_addr;
  assign out_rec.reg_value   = rec_r.reg_value;
  assign out_rec.delay_ticks = rec_r.delay_ticks;
  assign out_rec.write_valid = rec_r.write_valid;
  assign out_rec.last        = rec_r.last;

endmodule

`default_nettype wire

// ===== src/vgm_opl_command_converter_unit.sv =====
// ----------------------------------------------------------------------------
// vgm_opl_command_converter_unit
// Turns a VGM command byte stream into OPL register write records.
// ----------------------------------------------------------------------------
// Usage:
//   in_stream  : one stream byte per transfer (opcode or operand).
//   out_rec    : one register write record per transfer, carrying the delay
//                in 735-sample ticks that follows the write; the record made
//                by the end command has last set, write_valid shows whether
//                a write was pending.
//   Throughput : one byte per cycle sustained while out_rec keeps up.
//   Record path: the byte that completes the causing command queues it at its
//                transfer; the record builder pops it from the queue and loads
//                the record into the output register, which drives out_rec.
//   The parser and record builder are parted by a 4-entry command queue;
//   in_stream.ready drops only when that queue is full, i.e. after out_rec
//   has stalled long enough to back it up. A stalled record holds steady.
//   Reset (rst_n low, synchronous) empties the queue, clears the pending
//   write and delay, and returns the parser to expecting an opcode.
// ----------------------------------------------------------------------------
`default_nettype none
`include "vgm_opl_command_converter_unit_macros.svh"

module vgm_opl_command_converter_unit (
  input  wire          clk,
  input  wire          rst_n,
  vocc_in_if.sink      in_stream,
  vocc_out_if.source   out_rec
);
  import vocc_pkg::*;

  logic      push, pop;
  cmd_t      push_cmd, head;
  q_status_t q_stat;

  // byte parser
  vocc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .q_stat    (q_stat),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // command queue
  vocc_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  // record builder
  vocc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .head    (head),
    .q_stat  (q_stat),
    .pop     (pop),
    .out_rec (out_rec)
  );

  // checks
  `VOCC_ASSERT_IMP(a_no_push_full, clk, rst_n, push, !q_stat.full, "push into full queue")
  `VOCC_ASSERT_IMP(a_no_pop_empty, clk, rst_n, pop, !q_stat.empty, "pop from empty queue")
  `VOCC_ASSERT_NXT(a_push_fills, clk, rst_n, push && q_stat.empty, !q_stat.empty, "push lost")
  `VOCC_ASSERT_IMP(a_empty_rec_last, clk, rst_n, out_rec.valid && !out_rec.write_valid,
                   out_rec.last && (out_rec.delay_ticks == 16'd0),
                   "empty record not an end record")

endmodule

`default_nettype wire

// ===== sim/vgm_opl_command_converter_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vgm_opl_command_converter_unit_tb
// Drives VGM command bytes into the converter and checks every register write
// record against a behavioural copy of the parser, with random gaps on both
// channels and one long output stall that backs the block up.
// ----------------------------------------------------------------------------

module vgm_opl_command_converter_unit_tb;
  import vocc_pkg::*;

  localparam int          CLK_PERIOD   = 10;
  localparam int          RESET_CYCLES = 6;
  localparam int unsigned TICK_SAMPLES = 735;
  localparam int unsigned RANDOM_BYTES = 1000;
  localparam int unsigned LONG_WAITS   = 50;
  localparam int unsigned IDLE_PCT     = 11;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 20;
  // receiver schedule, in cycles from time zero
  localparam int unsigned HOLD_FROM    = 800;
  localparam int unsigned HOLD_CYCLES  = 100;
  localparam int unsigned STEADY_FROM  = 200;
  localparam int unsigned STEADY_LEN   = 400;
  // sender runs without gaps over this range of transfers
  localparam int unsigned BURST_FROM   = 700;
  localparam int unsigned BURST_LEN    = 300;

  localparam int          OPENING_LEN  = 25;
  localparam logic [7:0]  OPENING [OPENING_LEN] = '{
    OPC_END,                                            // end, nothing held
    OPC_WAIT_FRAME, OPC_WAIT_N, 8'h00, 8'h00,           // delay before any write
    OPC_WRITE_A, OPC_END, OPC_END,                      // opcodes taken as operands
    OPC_WAIT_N, 8'hFF, 8'hFF, OPC_WAIT_2FRAMES, OPC_WAIT_FRAME,
    8'h00, 8'hFF,                                       // unknown bytes skipped
    OPC_WRITE_B, 8'h00, 8'hFF,
    OPC_WRITE_C, 8'hFF, 8'h00,
    OPC_WAIT_N, 8'hDF, 8'h02,                           // exactly one tick
    OPC_END
  };

  // --------------------------------------------------------------------------
  // Expected record store and parser copy
  // --------------------------------------------------------------------------
  class opl_write_tracker;
    rec_t        pending_records[$];
    int unsigned mismatches;
    phase_t      phase;
    cmd_kind_t   kind;
    logic [7:0]  arg0;
    logic [15:0] ticks;
    logic        held;
    logic [7:0]  held_addr;
    logic [7:0]  held_value;

    function new();
      mismatches = 0;
      clear_state();
    endfunction

    function void clear_state();
      phase      = PH_OPCODE;
      kind       = CMD_WRITE;
      arg0       = 8'h00;
      ticks      = 16'h0000;
      held       = 1'b0;
      held_addr  = 8'h00;
      held_value = 8'h00;
    endfunction

    function string show(rec_t r);
      return $sformatf("addr=%02h value=%02h delay=%04h write=%0b last=%0b",
                       r.reg_addr, r.reg_value, r.delay_ticks, r.write_valid, r.last);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] %s", $realtime, msg);
    endfunction

    // one accepted stream byte: advance the parser, queue any record it makes
    function void note_byte(logic [7:0] b);
      rec_t        r;
      logic [15:0] samples;
      case (phase)
        PH_FIRST: begin
          arg0  = b;
          phase = PH_SECOND;
        end
        PH_SECOND: begin
          phase = PH_OPCODE;
          if (kind == CMD_DELAY) begin
            samples = {b, arg0};
            ticks   = ticks + 16'(samples / TICK_SAMPLES);
          end else begin
            if (held) begin
              r = '{reg_addr: held_addr, reg_value: held_value, delay_ticks: ticks,
                    write_valid: 1'b1, last: 1'b0};
              pending_records.push_back(r);
            end
            // any delay gathered before the first write is dropped here
            held       = 1'b1;
            held_addr  = arg0;
            held_value = b;
            ticks      = 16'h0000;
          end
        end
        default: begin
          phase = PH_OPCODE;
          case (b)
            OPC_WRITE_A, OPC_WRITE_B, OPC_WRITE_C: begin
              kind  = CMD_WRITE;
              phase = PH_FIRST;
            end
            OPC_WAIT_N: begin
              kind  = CMD_DELAY;
              phase = PH_FIRST;
            end
            OPC_WAIT_FRAME:   ticks = ticks + 16'(INC_FRAME);
            OPC_WAIT_2FRAMES: ticks = ticks + 16'(INC_2FRAMES);
            OPC_END: begin
              if (held)
                r = '{reg_addr: held_addr, reg_value: held_value, delay_ticks: ticks,
                      write_valid: 1'b1, last: 1'b1};
              else
                r = '{reg_addr: 8'h00, reg_value: 8'h00, delay_ticks: 16'h0000,
                      write_valid: 1'b0, last: 1'b1};
              pending_records.push_back(r);
              clear_state();
            end
            default: ;
          endcase
        end
      endcase
    endfunction

    // one accepted record against the oldest expectation
    function void check_record(rec_t got);
      rec_t want;
      if (pending_records.size() == 0) begin
        report({"unexpected record: ", show(got)});
        return;
      end
      want = pending_records.pop_front();
      if (got.reg_addr != want.reg_addr || got.reg_value != want.reg_value ||
          got.delay_ticks != want.delay_ticks || got.write_valid != want.write_valid ||
          got.last != want.last)
        report({"record mismatch: expected ", show(want), " got ", show(got)});
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycle_count = 0;
  int unsigned rx_cycle = 0;
  int unsigned bytes_sent = 0;
  int unsigned useful_bytes = 0;

  opl_write_tracker tracker;

  vocc_in_if  in_stream ();
  vocc_out_if out_rec ();

  vgm_opl_command_converter_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stream (in_stream),
    .out_rec   (out_rec)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // receiver: random back-pressure, one long hold-off, one steady stretch
  initial out_rec.ready = 1'b0;

  always @(negedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle >= HOLD_FROM && rx_cycle < HOLD_FROM + HOLD_CYCLES)
      out_rec.ready <= 1'b0;
    else if (rx_cycle >= STEADY_FROM && rx_cycle < STEADY_FROM + STEADY_LEN)
      out_rec.ready <= 1'b1;
    else
      out_rec.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // record monitor
  always @(posedge clk) begin
    if (rst_n && out_rec.valid && out_rec.ready)
      tracker.check_record({out_rec.reg_addr, out_rec.reg_value, out_rec.delay_ticks,
                            out_rec.write_valid, out_rec.last});
  end

  // one byte transfer; entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (bytes_sent < BURST_FROM || bytes_sent >= BURST_FROM + BURST_LEN) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_stream.valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_stream.valid       <= 1'b1;
    in_stream.stream_byte <= b;
    @(posedge clk);
    while (!in_stream.ready) @(posedge clk);
    tracker.note_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  // mostly well-formed commands with random operands, some broken or noise
  task automatic send_random_command();
    int unsigned pick;
    logic [7:0]  opc;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      case ($urandom_range(0, 2))
        0:       opc = OPC_WRITE_A;
        1:       opc = OPC_WRITE_B;
        default: opc = OPC_WRITE_C;
      endcase
      send_byte(opc);
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
      useful_bytes += 3;
    end else if (pick < 55) begin
      send_byte(OPC_WAIT_N);
      send_byte(8'($urandom_range(0, 255)));
      // small counts now and then, so some waits add nothing
      send_byte($urandom_range(0, 3) == 0 ? 8'h00 : 8'($urandom_range(0, 255)));
      useful_bytes += 3;
    end else if (pick < 65) begin
      send_byte(OPC_WAIT_FRAME);
      useful_bytes++;
    end else if (pick < 72) begin
      send_byte(OPC_WAIT_2FRAMES);
      useful_bytes++;
    end else if (pick < 77) begin
      send_byte(OPC_END);
      useful_bytes++;
    end else if (pick < 85) begin
      // truncated command: the next opcode lands in the operand slot
      send_byte($urandom_range(0, 1) ? OPC_WRITE_A : OPC_WAIT_N);
      send_byte(8'($urandom_range(0, 255)));
      useful_bytes += 2;
    end else begin
      send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  // stimulus
  initial begin
    tracker               = new();
    rst_n                 = 1'b0;
    in_stream.valid       = 1'b0;
    in_stream.stream_byte = 8'h00;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < OPENING_LEN; i++)
      send_byte(OPENING[i]);

    while (useful_bytes < RANDOM_BYTES)
      send_random_command();

    // run of maximum waits after one write, for a large delay
    send_byte(OPC_END);
    send_byte(OPC_WRITE_A);
    send_byte(8'($urandom_range(0, 255)));
    send_byte(8'($urandom_range(0, 255)));
    for (int i = 0; i < LONG_WAITS; i++) begin
      send_byte(OPC_WAIT_N);
      send_byte(8'hFF);
      send_byte(8'hFF);
    end
    send_byte(OPC_WAIT_2FRAMES);
    send_byte(OPC_END);
    in_stream.valid <= 1'b0;

    while (tracker.pending_records.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0 && tracker.pending_records.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
